// ===== rtl/igmps_pkg.sv =====
// Shared types, codes and helpers for the IGMP snooping table.
// Used by igmps_ctrl, igmps_dp and the top level igmp_snooping_table.
package igmps_pkg;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 192;
    localparam int NUM_PORTS  = 64;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_mtype;
    typedef logic [1:0] t_status;

    localparam t_op OP_MSG   = 2'd0;
    localparam t_op OP_CHECK = 2'd1;
    localparam t_op OP_TICK  = 2'd2;
    localparam t_op OP_SWEEP = 2'd3;

    localparam t_mtype MT_QUERY = 3'd0;
    localparam t_mtype MT_REP1  = 3'd1;
    localparam t_mtype MT_REP2  = 3'd2;
    localparam t_mtype MT_REP3  = 3'd3;
    localparam t_mtype MT_LEAVE = 3'd4;

    localparam t_status STS_DONE     = 2'd0;
    localparam t_status STS_DISABLED = 2'd1;
    localparam t_status STS_FULL     = 2'd2;
    localparam t_status STS_NOTFOUND = 2'd3;

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;

    localparam logic [10:0] REMOVED_MAX = 11'h7FF;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    tick;
        logic    gi_inc;
        logic    find_hit;
        logic    load_grp;
        logic    set_status;
        t_status status;
        logic    inc_gq;
        logic    inc_gr;
        logic    inc_gl;
        logic    set_q;
        logic    create;
        logic    mj_inc;
        logic    m_hit;
        logic    set_member;
        logic    rep_upd;
        logic    lv_rd;
        logic    lv_mv;
        logic    lv_fin;
        logic    wb;
        logic    sw_sel;
        logic    sw_cmp;
        logic    sw_fin;
        logic    out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op    in_op;
        t_op    op;
        t_mtype mtype;
        logic   en;
        logic   port_ok;
        logic   addr_zero;
        logic   slot_v;
        logic   full;
        logic   gi_lt_used;
        logic   active_gi;
        logic   key_hit;
        logic   mj_lt_cnt;
        logic   port_hit;
        logic   mfound;
        logic   out_free;
    } t_stat;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/igmp_snooping_table.sv =====
// IGMP snooping group table; one item at a time, s_axis_tready high only in idle.
// Tick advances time. Message or check scans used group slots for its key; a report,
// leave or check then scans the group's members. Sweep visits each used slot and ages
// the members of each active group. A beat held back by m_axis_tready adds its wait.
// Reset sets enable and a timeout of 260, clears time, slot count, active flags and
// totals; the RAM tables are left as they are and need no clearing pass.
module igmp_snooping_table import igmps_pkg::*; #(
    parameter int MAX_GROUPS  = 64,
    parameter int MAX_MEMBERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vlan_id[11:0], mcast_addr[43:12], port_index[49:44], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation[1:0], msg_type[4:2]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], is_member[2], removed_count[13:3], group_member_count[18:14],
    // querier[24:19], group_reports[56:25], group_leaves[88:57],
    // query_total[120:89], report_total[152:121], leave_total[184:153], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    igmps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    igmps_dp #(.MAX_GROUPS(MAX_GROUPS), .MAX_MEMBERS(MAX_MEMBERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten before its beat left");

    a_no_create_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.create |-> !stat.full)
        else $error("group created with the table full");

    a_ent_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.rep_upd, cmd.lv_mv, cmd.sw_cmp}))
        else $error("member RAM has two writers");
endmodule

// ===== rtl/igmps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module igmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/igmps_ctrl.sv =====
// Sequencing state machine for the IGMP snooping table.
// Depends on igmps_pkg; drives igmps_dp through t_cmd and reads t_stat.
module igmps_ctrl import igmps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_TICK    = 20'h00002,
        S_FIND_RD = 20'h00004,
        S_FIND_CM = 20'h00008,
        S_LG_WAIT = 20'h00010,
        S_LG_DAT  = 20'h00020,
        S_DISP    = 20'h00040,
        S_MS_RD   = 20'h00080,
        S_MS_CMP  = 20'h00100,
        S_MS_END  = 20'h00200,
        S_LV_MOVE = 20'h00400,
        S_LV_FIN  = 20'h00800,
        S_WB      = 20'h01000,
        S_OUT     = 20'h02000,
        S_SW_NEXT = 20'h04000,
        S_SW_WAIT = 20'h08000,
        S_SW_DAT  = 20'h10000,
        S_SW_RD   = 20'h20000,
        S_SW_CMP  = 20'h40000,
        S_SW_FIN  = 20'h80000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    case (i_stat.in_op)
                        OP_TICK:  n_state = S_TICK;
                        OP_SWEEP: n_state = S_SW_NEXT;
                        default:  n_state = S_FIND_RD;
                    endcase
                end
            end
            S_TICK: begin
                cmd.tick = 1'b1;
                n_state  = S_OUT;
            end
            // group search: key read is addressed by the scan index
            S_FIND_RD: n_state = i_stat.gi_lt_used ? S_FIND_CM : S_DISP;
            S_FIND_CM: begin
                if (i_stat.key_hit) begin
                    cmd.find_hit = 1'b1;
                    n_state      = S_LG_WAIT;
                end else begin
                    cmd.gi_inc = 1'b1;
                    n_state    = S_FIND_RD;
                end
            end
            S_LG_WAIT: n_state = S_LG_DAT;
            S_LG_DAT: begin
                cmd.load_grp = 1'b1;
                n_state      = S_DISP;
            end
            S_DISP: begin
                n_state = S_OUT;
                if (i_stat.op == OP_CHECK) begin
                    if (!i_stat.slot_v) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STS_NOTFOUND;
                    end else if (i_stat.port_ok) begin
                        n_state = S_MS_RD;
                    end
                end else if (!i_stat.en) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STS_DISABLED;
                end else if (i_stat.port_ok) begin
                    case (i_stat.mtype) inside
                        MT_QUERY: begin
                            cmd.inc_gq = 1'b1;
                            if (!i_stat.addr_zero) begin
                                if (!i_stat.slot_v) begin
                                    cmd.set_status = 1'b1;
                                    cmd.status     = STS_NOTFOUND;
                                end else begin
                                    cmd.set_q = 1'b1;
                                    n_state   = S_WB;
                                end
                            end
                        end
                        MT_REP1, MT_REP2, MT_REP3: begin
                            cmd.inc_gr = 1'b1;
                            if (i_stat.slot_v) begin
                                n_state = S_MS_RD;
                            end else if (i_stat.full) begin
                                cmd.set_status = 1'b1;
                                cmd.status     = STS_FULL;
                            end else begin
                                cmd.create = 1'b1;
                                n_state    = S_MS_RD;
                            end
                        end
                        MT_LEAVE: begin
                            cmd.inc_gl = 1'b1;
                            if (!i_stat.slot_v) begin
                                cmd.set_status = 1'b1;
                                cmd.status     = STS_NOTFOUND;
                            end else begin
                                n_state = S_MS_RD;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MS_RD: n_state = i_stat.mj_lt_cnt ? S_MS_CMP : S_MS_END;
            S_MS_CMP: begin
                if (i_stat.port_hit) begin
                    cmd.m_hit = 1'b1;
                    n_state   = S_MS_END;
                end else begin
                    cmd.mj_inc = 1'b1;
                    n_state    = S_MS_RD;
                end
            end
            S_MS_END: begin
                if (i_stat.op == OP_CHECK) begin
                    cmd.set_member = 1'b1;
                    n_state        = S_OUT;
                end else if (i_stat.mtype == MT_LEAVE) begin
                    if (i_stat.mfound) begin
                        cmd.lv_rd = 1'b1;
                        n_state   = S_LV_MOVE;
                    end else begin
                        n_state = S_LV_FIN;
                    end
                end else begin
                    cmd.rep_upd = 1'b1;
                    n_state     = S_WB;
                end
            end
            S_LV_MOVE: begin
                cmd.lv_mv = 1'b1;
                n_state   = S_LV_FIN;
            end
            S_LV_FIN: begin
                cmd.lv_fin = 1'b1;
                n_state    = S_WB;
            end
            S_WB: begin
                cmd.wb  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SW_NEXT: begin
                if (!i_stat.gi_lt_used) begin
                    n_state = S_OUT;
                end else if (i_stat.active_gi) begin
                    cmd.sw_sel = 1'b1;
                    n_state    = S_SW_WAIT;
                end else begin
                    cmd.gi_inc = 1'b1;
                end
            end
            S_SW_WAIT: n_state = S_SW_DAT;
            S_SW_DAT: begin
                cmd.load_grp = 1'b1;
                n_state      = S_SW_RD;
            end
            S_SW_RD: n_state = i_stat.mj_lt_cnt ? S_SW_CMP : S_SW_FIN;
            S_SW_CMP: begin
                cmd.sw_cmp = 1'b1;
                n_state    = S_SW_RD;
            end
            S_SW_FIN: begin
                cmd.sw_fin = 1'b1;
                n_state    = S_SW_NEXT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/igmps_dp.sv =====
// Datapath of the IGMP snooping table: tables in RAM, counters, result register.
// Depends on igmps_pkg and igmps_ram; steered by igmps_ctrl.
module igmps_dp import igmps_pkg::*; #(
    parameter int MAX_GROUPS  = 64,
    parameter int MAX_MEMBERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);
    localparam int GW = $clog2(MAX_GROUPS);
    localparam int SW = $clog2(MAX_GROUPS + 1);
    localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int EW = GW + MW;

    // control state
    logic                  r_en;
    logic [31:0]           r_tmo;
    logic [31:0]           r_time;
    logic [SW-1:0]         r_used;
    logic [MAX_GROUPS-1:0] r_active;
    logic [31:0]           r_gq, r_gr, r_gl;
    logic                  r_ov;

    // per-item working registers
    t_op           r_op;
    t_mtype        r_mt;
    logic [11:0]   r_vlan;
    logic [31:0]   r_addr;
    logic [5:0]    r_port;
    logic [SW-1:0] r_gi;
    logic [GW-1:0] r_g;
    logic          r_slot_v;
    logic [CW-1:0] r_cnt;
    logic [5:0]    r_q;
    logic [31:0]   r_rep, r_lv;
    logic [CW-1:0] r_mj;
    logic [MW-1:0] r_m;
    logic          r_mfound;
    logic [CW-1:0] r_w;
    t_status       r_status;
    logic          r_is_member;
    logic [10:0]   r_removed;
    logic [OUT_DATA_W-1:0] r_od;

    logic [43:0]   key, key_rdata;
    logic [CW-1:0] cnt_rdata, cnt_wdata, cnt_dec;
    logic [5:0]    q_rdata;
    logic [63:0]   ctr_rdata;
    logic [39:0]   ent_rdata, ent_wdata;
    logic [EW-1:0] ent_raddr, ent_waddr;
    logic [MW-1:0] ent_widx;
    logic          ent_we, age_ok, cnt_room;
    logic [GW-1:0] gi_idx;

    assign key      = {r_vlan, r_addr};
    assign gi_idx   = r_gi[GW-1:0];
    assign cnt_dec  = r_cnt - CW'(1);
    assign cnt_room = (r_cnt < CW'(MAX_MEMBERS));
    assign age_ok   = ((r_time - ent_rdata[39:8]) < r_tmo);

    assign ent_raddr = i_cmd.lv_rd ? {r_g, cnt_dec[MW-1:0]} : {r_g, r_mj[MW-1:0]};

    always_comb begin
        ent_widx = r_m;
        if (i_cmd.sw_cmp) begin
            ent_widx = r_w[MW-1:0];
        end else if (i_cmd.rep_upd && !r_mfound) begin
            ent_widx = r_cnt[MW-1:0];
        end
    end
    assign ent_waddr = {r_g, ent_widx};
    assign ent_wdata = i_cmd.rep_upd ? {r_time, r_mt[1:0], r_port} : ent_rdata;
    assign ent_we    = (i_cmd.rep_upd && (r_mfound || cnt_room)) || i_cmd.lv_mv
                     || (i_cmd.sw_cmp && age_ok);
    assign cnt_wdata = i_cmd.sw_fin ? r_w : r_cnt;

    igmps_ram #(.WIDTH(44), .DEPTH(MAX_GROUPS)) u_key_ram (
        .i_clk(i_clk), .i_we(i_cmd.wb), .i_waddr(r_g), .i_wdata(key),
        .i_raddr(gi_idx), .o_rdata(key_rdata)
    );
    igmps_ram #(.WIDTH(CW), .DEPTH(MAX_GROUPS)) u_cnt_ram (
        .i_clk(i_clk), .i_we(i_cmd.wb | i_cmd.sw_fin), .i_waddr(r_g), .i_wdata(cnt_wdata),
        .i_raddr(r_g), .o_rdata(cnt_rdata)
    );
    igmps_ram #(.WIDTH(6), .DEPTH(MAX_GROUPS)) u_q_ram (
        .i_clk(i_clk), .i_we(i_cmd.wb), .i_waddr(r_g), .i_wdata(r_q),
        .i_raddr(r_g), .o_rdata(q_rdata)
    );
    igmps_ram #(.WIDTH(64), .DEPTH(MAX_GROUPS)) u_ctr_ram (
        .i_clk(i_clk), .i_we(i_cmd.wb), .i_waddr(r_g), .i_wdata({r_lv, r_rep}),
        .i_raddr(r_g), .o_rdata(ctr_rdata)
    );
    igmps_ram #(.WIDTH(40), .DEPTH(MAX_GROUPS << MW)) u_ent_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    always_comb begin
        o_stat            = '0;
        o_stat.in_op      = i_in_user[1:0];
        o_stat.op         = r_op;
        o_stat.mtype      = r_mt;
        o_stat.en         = r_en;
        o_stat.port_ok    = ({3'b000, r_port} < 9'(NUM_PORTS));
        o_stat.addr_zero  = (r_addr == 32'd0);
        o_stat.slot_v     = r_slot_v;
        o_stat.full       = (r_used == SW'(MAX_GROUPS));
        o_stat.gi_lt_used = (r_gi < r_used);
        o_stat.active_gi  = r_active[gi_idx];
        o_stat.key_hit    = r_active[gi_idx] && (key_rdata == key);
        o_stat.mj_lt_cnt  = (r_mj < r_cnt);
        o_stat.port_hit   = (ent_rdata[5:0] == r_port);
        o_stat.mfound     = r_mfound;
        o_stat.out_free   = !r_ov || i_out_ready;
    end

    // registers that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b1;
            r_tmo    <= 32'd260;
            r_time   <= '0;
            r_used   <= '0;
            r_active <= '0;
            r_gq     <= '0;
            r_gr     <= '0;
            r_gl     <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE:  r_en  <= i_cfg_data[0];
                    CFG_TIMEOUT: r_tmo <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.tick)   r_time <= r_time + 32'd1;
            if (i_cmd.inc_gq) r_gq   <= sat_inc32(r_gq);
            if (i_cmd.inc_gr) r_gr   <= sat_inc32(r_gr);
            if (i_cmd.inc_gl) r_gl   <= sat_inc32(r_gl);
            if (i_cmd.create) begin
                r_used                    <= r_used + SW'(1);
                r_active[r_used[GW-1:0]]  <= 1'b1;
            end
            if (i_cmd.lv_fin && (r_cnt == '0)) r_active[r_g] <= 1'b0;
            if (i_cmd.sw_fin && (r_w == '0))   r_active[r_g] <= 1'b0;
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers, loaded before use
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_in_user[1:0];
            r_mt        <= i_in_user[4:2];
            r_vlan      <= i_in_data[11:0];
            r_addr      <= i_in_data[43:12];
            r_port      <= i_in_data[49:44];
            r_gi        <= '0;
            r_slot_v    <= 1'b0;
            r_mfound    <= 1'b0;
            r_status    <= STS_DONE;
            r_is_member <= 1'b0;
            r_removed   <= '0;
        end
        if (i_cmd.gi_inc || i_cmd.sw_fin) r_gi <= r_gi + SW'(1);
        if (i_cmd.find_hit) begin
            r_g      <= gi_idx;
            r_slot_v <= 1'b1;
        end
        if (i_cmd.sw_sel) r_g <= gi_idx;
        if (i_cmd.load_grp) begin
            r_cnt    <= cnt_rdata;
            r_q      <= q_rdata;
            r_rep    <= ctr_rdata[31:0];
            r_lv     <= ctr_rdata[63:32];
            r_mj     <= '0;
            r_w      <= '0;
            r_mfound <= 1'b0;
        end
        if (i_cmd.create) begin
            r_g      <= r_used[GW-1:0];
            r_slot_v <= 1'b1;
            r_cnt    <= '0;
            r_q      <= '0;
            r_rep    <= '0;
            r_lv     <= '0;
            r_mj     <= '0;
            r_mfound <= 1'b0;
        end
        if (i_cmd.set_status) r_status    <= i_cmd.status;
        if (i_cmd.set_q)      r_q         <= r_port;
        if (i_cmd.mj_inc)     r_mj        <= r_mj + CW'(1);
        if (i_cmd.m_hit) begin
            r_mfound <= 1'b1;
            r_m      <= r_mj[MW-1:0];
        end
        if (i_cmd.set_member) r_is_member <= r_mfound;
        if (i_cmd.rep_upd) begin
            r_rep <= sat_inc32(r_rep);
            if (!r_mfound && cnt_room) r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.lv_rd)  r_cnt <= cnt_dec;
        if (i_cmd.lv_fin) r_lv  <= sat_inc32(r_lv);
        if (i_cmd.sw_cmp) begin
            r_mj <= r_mj + CW'(1);
            if (age_ok) begin
                r_w <= r_w + CW'(1);
            end else if (r_removed != REMOVED_MAX) begin
                r_removed <= r_removed + 11'd1;
            end
        end
        if (i_cmd.out_load) begin
            r_od <= {7'd0, r_gl, r_gr, r_gq,
                     r_slot_v ? r_lv : 32'd0,
                     r_slot_v ? r_rep : 32'd0,
                     r_slot_v ? r_q : 6'd0,
                     r_slot_v ? 5'(r_cnt) : 5'd0,
                     r_removed, r_is_member, r_status};
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
endmodule
